/* src/ikvt_pkg.sv */
// ikvt_pkg: shared types, character codes and byte classes for the
// key/value tokenizer. No dependencies; used by ini_key_value_tokenizer_top.
`default_nettype none

package ikvt_pkg;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_BETWEEN  = 7'b0000001,
    PH_COMMENT  = 7'b0000010,
    PH_NAME     = 7'b0000100,
    PH_NAME_WS  = 7'b0001000,
    PH_DISCARD  = 7'b0010000,
    PH_AFTER_EQ = 7'b0100000,
    PH_VALUE    = 7'b1000000
  } phase_t;

  // Token event kinds
  typedef enum logic [2:0] {
    EV_NAME_BYTE  = 3'd0,
    EV_ACCEPT     = 3'd1,
    EV_REJECT     = 3'd2,
    EV_VALUE_BYTE = 3'd3,
    EV_PAIR_END   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } event_t;

  // Output queue: room for one pending word plus the two a byte can add
  localparam int QDepth  = 3;
  localparam int QIdxW   = $clog2(QDepth);
  localparam int QCountW = $clog2(QDepth + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic logic is_name_char(input logic [7:0] c);
    return (c == CH_UNDER) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

/* src/ini_key_value_tokenizer_top.sv */
// ini_key_value_tokenizer_top: byte-stream tokenizer for NAME=value lines.
// Depends on ikvt_pkg (phase and event types, character classes).
//
// Usage:
//  - Input stream (s_*): one text byte per word. s_tlast marks the final
//    byte of a text; after it a pending name is rejected, a pending value
//    gets its pair end, and the parser returns to "between lines".
//  - Output stream (m_*): one token event per word. m_tuser carries the
//    event kind (name byte, accept, reject, value byte, pair end), m_tdata
//    the name/value byte (zero for the other kinds), and m_tlast marks the
//    last event caused by one input byte.
//  - Each byte is classified against the phase register combinationally;
//    its zero, one or two events land in a three-entry output queue, whose
//    head drives the m_* port. The queue is registered, so with an empty
//    queue the first event is on m_tvalid in the cycle after input accept.
//  - Throughput: one byte per cycle while m_tready is high and each byte
//    yields at most one event; a two-event byte drops s_tready until a word
//    is taken. The output port (one word per cycle) sets the sustained rate.
//  - s_tready is high while the queue holds at most one word, so a byte is
//    still taken while a finished word waits on a stalled receiver. A
//    stall of m_tready simply holds the queue; nothing is dropped.
//  - rst (synchronous, active high) empties the queue and sets the phase to
//    "between lines". No clearing pass is needed.
`default_nettype none

module ini_key_value_tokenizer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input stream
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // final_byte
  // Output stream
  output      logic       m_tvalid,
  input  wire logic       m_tready,
  output      logic [7:0] m_tdata,   // [7:0] event_byte
  output      logic [2:0] m_tuser,   // [2:0] event_kind
  output      logic       m_tlast    // run_last
);

  ikvt_pkg::phase_t phase, phase_next, phase_mid;

  ikvt_pkg::event_t q [ikvt_pkg::QDepth];
  ikvt_pkg::event_t q_next [ikvt_pkg::QDepth];
  logic [ikvt_pkg::QCountW-1:0] count, count_next, count_mid;

  logic s_fire, m_fire;

  // Events of the byte itself and of the end-of-text flush
  logic            step_valid;
  ikvt_pkg::kind_t step_kind;
  logic [7:0]      step_data;
  logic            fin_valid;
  ikvt_pkg::kind_t fin_kind;
  ikvt_pkg::event_t ev0, ev1;
  logic [1:0]      ev_n;
  logic [ikvt_pkg::QCountW-1:0] slot1;

  assign s_tready = (count <= ikvt_pkg::QCountW'(1));
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign m_fire   = m_tvalid && m_tready;

  assign m_tdata = q[0].data;
  assign m_tuser = q[0].kind;
  assign m_tlast = q[0].last;

  // Byte classification against the current phase
  always_comb begin
    step_valid = 1'b0;
    step_kind  = ikvt_pkg::EV_NAME_BYTE;
    step_data  = 8'h00;
    phase_mid  = phase;
    unique case (phase)
      ikvt_pkg::PH_COMMENT, ikvt_pkg::PH_DISCARD: begin
        if (ikvt_pkg::is_eol(s_tdata)) phase_mid = ikvt_pkg::PH_BETWEEN;
      end
      ikvt_pkg::PH_NAME, ikvt_pkg::PH_NAME_WS: begin
        if (phase == ikvt_pkg::PH_NAME && ikvt_pkg::is_name_char(s_tdata)) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_NAME_BYTE;
          step_data  = s_tdata;
        end else if (ikvt_pkg::is_blank(s_tdata)) begin
          phase_mid = ikvt_pkg::PH_NAME_WS;
        end else if (s_tdata == ikvt_pkg::CH_EQ) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_ACCEPT;
          phase_mid  = ikvt_pkg::PH_AFTER_EQ;
        end else if (ikvt_pkg::is_eol(s_tdata)) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_REJECT;
          phase_mid  = ikvt_pkg::PH_BETWEEN;
        end else begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_REJECT;
          phase_mid  = ikvt_pkg::PH_DISCARD;
        end
      end
      ikvt_pkg::PH_AFTER_EQ: begin
        if (ikvt_pkg::is_blank(s_tdata)) begin
          phase_mid = ikvt_pkg::PH_AFTER_EQ;
        end else if (s_tdata == ikvt_pkg::CH_QUOTE) begin
          phase_mid = ikvt_pkg::PH_VALUE;   // opening quote dropped
        end else if (ikvt_pkg::is_eol(s_tdata)) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_PAIR_END;
          phase_mid  = ikvt_pkg::PH_BETWEEN;
        end else begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_VALUE_BYTE;
          step_data  = s_tdata;
          phase_mid  = ikvt_pkg::PH_VALUE;
        end
      end
      ikvt_pkg::PH_VALUE: begin
        if (ikvt_pkg::is_eol(s_tdata)) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_PAIR_END;
          phase_mid  = ikvt_pkg::PH_BETWEEN;
        end else if (s_tdata == ikvt_pkg::CH_QUOTE) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_PAIR_END;
          phase_mid  = ikvt_pkg::PH_DISCARD;   // closing quote: drop the rest
        end else begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_VALUE_BYTE;
          step_data  = s_tdata;
        end
      end
      default: begin  // between lines
        if (ikvt_pkg::is_blank(s_tdata) || ikvt_pkg::is_eol(s_tdata)) begin
          phase_mid = ikvt_pkg::PH_BETWEEN;
        end else if (s_tdata == ikvt_pkg::CH_HASH) begin
          phase_mid = ikvt_pkg::PH_COMMENT;
        end else if (ikvt_pkg::is_name_char(s_tdata)) begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_NAME_BYTE;
          step_data  = s_tdata;
          phase_mid  = ikvt_pkg::PH_NAME;
        end else if (s_tdata == ikvt_pkg::CH_EQ) begin
          // empty name
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_ACCEPT;
          phase_mid  = ikvt_pkg::PH_AFTER_EQ;
        end else begin
          step_valid = 1'b1;
          step_kind  = ikvt_pkg::EV_REJECT;
          phase_mid  = ikvt_pkg::PH_DISCARD;
        end
      end
    endcase
  end

  // End-of-text flush
  always_comb begin
    fin_valid  = 1'b0;
    fin_kind   = ikvt_pkg::EV_REJECT;
    phase_next = phase_mid;
    if (s_tlast) begin
      phase_next = ikvt_pkg::PH_BETWEEN;
      if (phase_mid == ikvt_pkg::PH_NAME || phase_mid == ikvt_pkg::PH_NAME_WS) begin
        fin_valid = 1'b1;
        fin_kind  = ikvt_pkg::EV_REJECT;
      end else if (phase_mid == ikvt_pkg::PH_AFTER_EQ ||
                   phase_mid == ikvt_pkg::PH_VALUE) begin
        fin_valid = 1'b1;
        fin_kind  = ikvt_pkg::EV_PAIR_END;
      end
    end
  end

  // Order the events: byte event first, flush event second
  always_comb begin
    ev_n = {1'b0, step_valid} + {1'b0, fin_valid};
    ev1  = '{kind: fin_kind, data: 8'h00, last: 1'b1};
    if (step_valid) begin
      ev0 = '{kind: step_kind, data: step_data, last: !fin_valid};
    end else begin
      ev0 = ev1;
    end
  end

  // Output queue: shift out at the head, append behind the survivors
  always_comb begin
    for (int i = 0; i < ikvt_pkg::QDepth; i++) begin
      q_next[i] = q[i];
    end
    if (m_fire) begin
      for (int i = 0; i < ikvt_pkg::QDepth - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    count_mid  = count - ikvt_pkg::QCountW'(m_fire);
    slot1      = count_mid + ikvt_pkg::QCountW'(1);
    count_next = count_mid;
    if (s_fire) begin
      if (ev_n != 2'd0) q_next[count_mid[ikvt_pkg::QIdxW-1:0]] = ev0;
      if (ev_n == 2'd2) q_next[slot1[ikvt_pkg::QIdxW-1:0]] = ev1;
      count_next = count_mid + ikvt_pkg::QCountW'(ev_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ikvt_pkg::PH_BETWEEN;
      count <= '0;
    end else begin
      if (s_fire) phase <= phase_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ikvt_pkg::QDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

  // The final byte of a text always leaves the parser between lines
  a_last_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tlast) |=> (phase == ikvt_pkg::PH_BETWEEN))
    else $error("phase not cleared after final byte");

  // Only name and value bytes carry data
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ikvt_pkg::EV_NAME_BYTE &&
     m_tuser != ikvt_pkg::EV_VALUE_BYTE) |-> (m_tdata == 8'h00))
    else $error("nonzero data on a marker event");

  // Both events of one byte are queued together: a non-last word is followed
  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    (m_fire && !m_tlast) |=> m_tvalid)
    else $error("second event of a byte missing");

  // While the input is held off the queue cannot grow
  a_no_growth_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> (count <= $past(count)))
    else $error("queue grew while input was stalled");

endmodule

`default_nettype wire
